@@ hdl/cevq_pkg.sv @@
// Shared types and constants of the capture event queue.
`default_nettype none

package cevq_pkg;

    localparam int unsigned CHANNELS_DEF   = 4;
    localparam int unsigned RING_DEPTH_DEF = 128;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned ENTRY_W = STAMP_W + 1;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_POPPED  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADCH   = 3'd4
    } status_t;

    // Decision taken on an accepted beat, carried to the result stage
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   drop_count;
        logic                 pop;
    } resp_t;

endpackage

`default_nettype wire

@@ hdl/multi_channel_capture_event_queue.sv @@
// Top level of the multi-channel capture event queue.
`default_nettype none

// One ring queue of capture events (32-bit timestamp plus edge polarity) per
// channel, CHANNELS rings of RING_DEPTH slots each; a ring keeps one slot free,
// so it holds at most RING_DEPTH-1 events. Each slave beat is one access: a
// push (tuser op = 0) or a pop (op = 1) on the channel in tdata. Every beat
// gives exactly one master beat with the status (pushed, dropped full,
// popped, empty, bad channel), the popped event and the channel's overflow
// count after the access. A push to a full ring is dropped and bumps the
// channel's 32-bit wrapping counter; a channel at or beyond CHANNELS touches
// no state and returns zeros. Throughput is one beat per clock while the
// master takes results: the pointers and counters sit in flip-flops and the
// decision is made on the accepting edge, while the event store is a
// single-port RAM doing one write or one read per cycle. A beat's result is
// held in s1 (decision, RAM read data) and then in the output register, which
// drives master tvalid. While that register waits, one more beat can be taken
// into s1; a full s1 behind it holds s_tready low. Reset clears pointers,
// counters and valid flags; the store itself is never cleared and needs no
// init sweep, since a slot is only read after a push wrote it.
module multi_channel_capture_event_queue
    import cevq_pkg::*;
#(
    parameter int unsigned CHANNELS   = CHANNELS_DEF,   // 1 to 8
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF  // 2 to 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // channel[2:0], stamp[34:3], polarity[35], zero pad
    input  wire logic [0:0]  s_tuser,   // op[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // out_stamp[31:0], out_polarity[32],
                                        // drop_count[64:33], zero pad
    output logic      [2:0]  m_tuser    // status[2:0]
);

    localparam int unsigned DEPTH  = CHANNELS * RING_DEPTH;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input unpacking
    logic               in_op;
    logic [2:0]         in_channel;
    logic [STAMP_W-1:0] in_stamp;
    logic               in_polarity;
    logic               take;

    assign in_op       = s_tuser[0];
    assign in_channel  = s_tdata[2:0];
    assign in_stamp    = s_tdata[34:3];
    assign in_polarity = s_tdata[35];

    // Decision and store
    resp_t              resp;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    // Pipeline registers
    logic               s1_valid_reg;
    resp_t              s1_resp_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [STAMP_W-1:0] out_stamp_reg;
    logic               out_pol_reg;
    logic [COUNT_W-1:0] out_drop_reg;
    logic               s1_move;

    // s1 moves on when the output register is free or being emptied
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign take     = s_tvalid && s_tready;

    cevq_ctrl #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .op        (in_op),
        .channel   (in_channel),
        .stamp     (in_stamp),
        .polarity  (in_polarity),
        .resp      (resp),
        .mem_wr_en (mem_wr_en),
        .mem_rd_en (mem_rd_en),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    // RAM read data stays put while s1 stalls: no read is issued then
    cevq_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_resp_reg <= resp;
        end
        if (s1_move)
        begin
            out_status_reg <= s1_resp_reg.status;
            out_drop_reg   <= s1_resp_reg.drop_count;
            out_stamp_reg  <= s1_resp_reg.pop ? mem_rdata[STAMP_W-1:0] : '0;
            out_pol_reg    <= s1_resp_reg.pop ? mem_rdata[STAMP_W] : 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_drop_reg, out_pol_reg, out_stamp_reg};

    // A RAM read is only issued for a pop that found an event
    a_read_is_pop : assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> (s1_valid_reg && s1_resp_reg.pop
                       && s1_resp_reg.status == ST_POPPED))
        else $error("RAM read without a matching pop");

    // Never both a write and a read of the store in one cycle
    a_one_access : assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("store written and read in the same cycle");

    // A full output register that is not drained blocks a waiting s1 beat
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("beat accepted while the pipeline is blocked");

    // Bad channel results carry no count and no event
    a_badch_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_BADCH) |-> (m_tdata[64:0] == '0))
        else $error("bad-channel result carries data");

endmodule

`default_nettype wire

@@ hdl/cevq_ram.sv @@
// Event store: single-port RAM with registered read data.
`default_nettype none

module cevq_ram
    import cevq_pkg::*;
#(
    parameter int unsigned DEPTH  = CHANNELS_DEF * RING_DEPTH_DEF,
    parameter int unsigned ADDR_W = $clog2(CHANNELS_DEF * RING_DEPTH_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic [ENTRY_W-1:0] wdata,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/cevq_ctrl.sv @@
// Per-channel ring pointers, overflow counters and the push/pop decision.
`default_nettype none

module cevq_ctrl
    import cevq_pkg::*;
#(
    parameter int unsigned CHANNELS   = CHANNELS_DEF,
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
    parameter int unsigned ADDR_W     = $clog2(CHANNELS_DEF * RING_DEPTH_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic               op,
    input  wire logic [2:0]         channel,
    input  wire logic [STAMP_W-1:0] stamp,
    input  wire logic               polarity,
    output resp_t                   resp,
    output logic                    mem_wr_en,
    output logic                    mem_rd_en,
    output logic      [ADDR_W-1:0]  mem_addr,
    output logic      [ENTRY_W-1:0] mem_wdata
);

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [PTR_W-1:0]   head_reg [CHANNELS];
    logic [PTR_W-1:0]   tail_reg [CHANNELS];
    logic [COUNT_W-1:0] drop_reg [CHANNELS];

    logic               ch_bad;
    logic [CH_W-1:0]    ch_idx;
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] cnt_inc;
    logic               do_push;
    logic               do_pop;
    logic               do_drop;
    logic [ADDR_W-1:0]  ring_base;

    always_comb
    begin
        ch_bad      = {1'b0, channel} >= 4'(CHANNELS);
        ch_idx      = channel[CH_W-1:0];
        wr_ptr      = head_reg[ch_idx];
        rd_ptr      = tail_reg[ch_idx];
        wr_ptr_next = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        rd_ptr_next = (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        full        = (wr_ptr_next == rd_ptr);  // one slot always kept free
        empty       = (rd_ptr == wr_ptr);
        cnt         = drop_reg[ch_idx];
        cnt_inc     = cnt + 1'b1;

        do_push = !ch_bad && !op && !full;
        do_drop = !ch_bad && !op && full;
        do_pop  = !ch_bad && op && !empty;

        resp.pop = do_pop;
        if (ch_bad)
        begin
            resp.status     = ST_BADCH;
            resp.drop_count = '0;
        end
        else
        begin
            resp.drop_count = do_drop ? cnt_inc : cnt;
            if (!op)
            begin
                resp.status = full ? ST_DROPPED : ST_PUSHED;
            end
            else
            begin
                resp.status = empty ? ST_EMPTY : ST_POPPED;
            end
        end

        ring_base = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH);
        mem_addr  = ring_base + ADDR_W'(op ? rd_ptr : wr_ptr);
        mem_wdata = {polarity, stamp};
        mem_wr_en = take && do_push;
        mem_rd_en = take && do_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                drop_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            if (do_push)
            begin
                head_reg[ch_idx] <= wr_ptr_next;
            end
            if (do_pop)
            begin
                tail_reg[ch_idx] <= rd_ptr_next;
            end
            if (do_drop)
            begin
                drop_reg[ch_idx] <= cnt_inc;
            end
        end
    end

endmodule

`default_nettype wire
